/* hdl/keyed_match_table_with_wildcards_assert.svh */
// Assertion macros for the keyed match table.
`ifndef KEYED_MATCH_TABLE_WITH_WILDCARDS_ASSERT_SVH
`define KEYED_MATCH_TABLE_WITH_WILDCARDS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KMT_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define KMT_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/kmt_pkg.sv */
// Shared types and codes for the keyed match table.
package kmt_pkg;

  localparam int HASH_W      = 32;
  localparam int SLOT_W      = 6;
  localparam int ACTION_W    = 3;
  localparam int STATUS_W    = 3;
  localparam int CLASS_W     = 2;
  localparam int COUNT_OUT_W = 7;

  // Action codes on the input item
  localparam logic [ACTION_W-1:0] ACT_ADD      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RM_KEY   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RM_IDX   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLASSIFY = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_MEMBER   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_READ     = 3'd5;

  // Status codes on the result item
  localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BLANK = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE  = 3'd4;

  // Classify results
  localparam logic [CLASS_W-1:0] MC_NONE  = 2'd0;
  localparam logic [CLASS_W-1:0] MC_GROUP = 2'd1;
  localparam logic [CLASS_W-1:0] MC_EXACT = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [HASH_W-1:0]   name_hash;
    logic [HASH_W-1:0]   group_hash;
    logic                name_blank;
    logic                group_blank;
    logic                players_only;
    logic [SLOT_W-1:0]   slot;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [CLASS_W-1:0]     match_class;
    logic                   is_member;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [HASH_W-1:0]      read_name_hash;
    logic [HASH_W-1:0]      read_group_hash;
    logic                   read_name_blank;
  } out_t;

  // One stored table entry
  typedef struct packed {
    logic [HASH_W-1:0] name_hash;
    logic [HASH_W-1:0] group_hash;
    logic              name_blank;
  } entry_t;

  // Decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_ADD,
    OP_RM_KEY,
    OP_RM_IDX,
    OP_CLASSIFY,
    OP_MEMBER,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [HASH_W-1:0] name_hash;
    logic [HASH_W-1:0] group_hash;
    logic              name_blank;
    logic              blank_key;
    logic              players_only;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SCAN,
    BS_SHIFT,
    BS_MOD,
    BS_RDDATA,
    BS_DONE
  } back_state_t;

endpackage

/* hdl/keyed_match_table_with_wildcards.sv */
// Top level of the keyed match table: front decoder, command queue, back sequencer.
// Add, remove by key, classify and membership scan the held entries; remove by index
// and a remove by key that hits then shift the entries above the slot down; read
// reduces the slot modulo the entry count by subtraction and reads that entry.
// Throughput: one item at a time in the back sequencer; the front queues two more items.
// Reset clears the entry count and all handshake state; table contents are not cleared.
`include "keyed_match_table_with_wildcards_assert.svh"
module keyed_match_table_with_wildcards #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kmt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output kmt_pkg::out_t out_data
);

  kmt_pkg::q_head_t q_head;
  logic             q_pop;

  kmt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  kmt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Sequencer never pops an empty queue
  `KMT_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, q_head.valid, "pop from empty queue")

  // An accepted item is in the queue on the next cycle
  `KMT_ASSERT_NXT(a_push_visible, clk, rst_n, in_valid && in_ready, q_head.valid, "item lost")

  // Failed actions carry no classify or membership result
  `KMT_ASSERT_IMP(a_fail_clean, clk, rst_n, out_valid && (out_data.status != kmt_pkg::ST_DONE),
                  (out_data.match_class == kmt_pkg::MC_NONE) && !out_data.is_member,
                  "result fields set on failed action")

endmodule

/* hdl/kmt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kmt_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/kmt_front.sv */
// Front end: accepts items, decodes the action and queues commands.
module kmt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  kmt_pkg::in_t    in_data,
  output kmt_pkg::q_head_t q_head,
  input  logic            q_pop
);

  localparam int QD  = 2;
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  kmt_pkg::cmd_t  q_r [QD];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  kmt_pkg::cmd_t  dec_cmd;
  logic           push;

  // Action decode
  always_comb begin
    dec_cmd.name_hash    = in_data.name_hash;
    dec_cmd.group_hash   = in_data.group_hash;
    dec_cmd.name_blank   = in_data.name_blank;
    dec_cmd.blank_key    = in_data.name_blank & in_data.group_blank;
    dec_cmd.players_only = in_data.players_only;
    dec_cmd.slot         = in_data.slot;
    unique case (in_data.action)
      kmt_pkg::ACT_ADD:      dec_cmd.op = kmt_pkg::OP_ADD;
      kmt_pkg::ACT_RM_KEY:   dec_cmd.op = kmt_pkg::OP_RM_KEY;
      kmt_pkg::ACT_RM_IDX:   dec_cmd.op = kmt_pkg::OP_RM_IDX;
      kmt_pkg::ACT_CLASSIFY: dec_cmd.op = kmt_pkg::OP_CLASSIFY;
      kmt_pkg::ACT_MEMBER:   dec_cmd.op = kmt_pkg::OP_MEMBER;
      kmt_pkg::ACT_READ:     dec_cmd.op = kmt_pkg::OP_READ;
      default:               dec_cmd.op = kmt_pkg::OP_NOP;
    endcase
  end

  // Queue pointers and fill
  assign in_ready = (cnt_r != QCW'(QD));
  assign push     = in_valid & in_ready;

  always_comb begin
    wptr_nxt = push ? wptr_r + QAW'(1) : wptr_r;
    rptr_nxt = q_pop ? rptr_r + QAW'(1) : rptr_r;
    cnt_nxt  = cnt_r + QCW'(push) - QCW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= dec_cmd;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.cmd   = q_r[rptr_r];

endmodule

/* hdl/kmt_back.sv */
// Back end: sequencer that scans, shifts and reads the table, plus result register.
module kmt_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  kmt_pkg::q_head_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output kmt_pkg::out_t    out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > kmt_pkg::SLOT_W) ? CW : kmt_pkg::SLOT_W;
  localparam int EW = (CW > kmt_pkg::COUNT_OUT_W) ? CW : kmt_pkg::COUNT_OUT_W;

  kmt_pkg::back_state_t state_r, state_nxt;
  kmt_pkg::cmd_t        cmd_r, cmd_nxt;
  kmt_pkg::out_t        res_r, res_nxt;
  kmt_pkg::out_t        out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        pidx_r, pidx_nxt;
  logic                 pend_r, pend_nxt;
  logic [XW-1:0]        rem_r, rem_nxt;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  kmt_pkg::entry_t      ram_wdata, ram_rdata;

  kmt_pkg::cmd_t        qc;
  logic                 gh_eq, nh_eq, scan_hit, walk_end, issue_ok;
  logic                 add_full, slot_in_range, rem_ge, out_free, out_load;
  logic [CW-1:0]        hole_addr;
  logic [EW-1:0]        cnt_ext;

  kmt_ram #(
    .WIDTH ($bits(kmt_pkg::entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Compare the entry returned by the RAM against the current key
  assign qc            = q_head.cmd;
  assign gh_eq         = (ram_rdata.group_hash == cmd_r.group_hash);
  assign nh_eq         = (ram_rdata.name_hash == cmd_r.name_hash);
  assign issue_ok      = (idx_r < count_r);
  assign walk_end      = !pend_r && !issue_ok;
  assign add_full      = (count_r == CW'(TABLE_DEPTH));
  assign slot_in_range = (XW'(qc.slot) < XW'(count_r));
  assign rem_ge        = (rem_r >= XW'(count_r));
  assign out_free      = !out_valid_r || out_ready;
  assign hole_addr     = pidx_r - CW'(1);
  assign cnt_ext       = EW'(count_r);

  // Per-operation hit condition on a returned entry
  always_comb begin
    case (cmd_r.op) inside
      kmt_pkg::OP_ADD,
      kmt_pkg::OP_RM_KEY:   scan_hit = pend_r && gh_eq && nh_eq;
      kmt_pkg::OP_CLASSIFY: scan_hit = pend_r && gh_eq && !ram_rdata.name_blank && nh_eq;
      kmt_pkg::OP_MEMBER:   scan_hit = pend_r && gh_eq &&
                                       ((!cmd_r.players_only && ram_rdata.name_blank) || nh_eq);
      default:              scan_hit = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kmt_pkg::BS_IDLE: begin
        if (q_head.valid) begin
          case (qc.op) inside
            kmt_pkg::OP_ADD:
              state_nxt = (add_full || qc.blank_key) ? kmt_pkg::BS_DONE : kmt_pkg::BS_SCAN;
            kmt_pkg::OP_RM_KEY, kmt_pkg::OP_CLASSIFY, kmt_pkg::OP_MEMBER:
              state_nxt = kmt_pkg::BS_SCAN;
            kmt_pkg::OP_RM_IDX:
              state_nxt = slot_in_range ? kmt_pkg::BS_SHIFT : kmt_pkg::BS_DONE;
            kmt_pkg::OP_READ:
              state_nxt = (count_r == '0) ? kmt_pkg::BS_DONE : kmt_pkg::BS_MOD;
            default:
              state_nxt = kmt_pkg::BS_DONE;
          endcase
        end
      end
      kmt_pkg::BS_SCAN: begin
        if (scan_hit) begin
          state_nxt = (cmd_r.op == kmt_pkg::OP_RM_KEY) ? kmt_pkg::BS_SHIFT : kmt_pkg::BS_DONE;
        end else if (walk_end) begin
          state_nxt = kmt_pkg::BS_DONE;
        end
      end
      kmt_pkg::BS_SHIFT: begin
        if (walk_end) begin
          state_nxt = kmt_pkg::BS_DONE;
        end
      end
      kmt_pkg::BS_MOD: begin
        if (!rem_ge) begin
          state_nxt = kmt_pkg::BS_RDDATA;
        end
      end
      kmt_pkg::BS_RDDATA: state_nxt = kmt_pkg::BS_DONE;
      kmt_pkg::BS_DONE: begin
        if (out_free) begin
          state_nxt = kmt_pkg::BS_IDLE;
        end
      end
      default: state_nxt = kmt_pkg::BS_IDLE;
    endcase
  end

  // Datapath, RAM controls and queue pop
  always_comb begin
    cmd_nxt   = cmd_r;
    res_nxt   = res_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pidx_nxt  = pidx_r;
    pend_nxt  = pend_r;
    rem_nxt   = rem_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata = ram_rdata;
    out_load  = 1'b0;
    unique case (state_r)
      kmt_pkg::BS_IDLE: begin
        if (q_head.valid) begin
          q_pop          = 1'b1;
          cmd_nxt        = qc;
          res_nxt        = '0;
          res_nxt.status = kmt_pkg::ST_DONE;
          idx_nxt        = '0;
          pend_nxt       = 1'b0;
          case (qc.op)
            kmt_pkg::OP_ADD: begin
              if (add_full) begin
                res_nxt.status = kmt_pkg::ST_FULL;
              end else if (qc.blank_key) begin
                res_nxt.status = kmt_pkg::ST_BLANK;
              end
            end
            kmt_pkg::OP_RM_IDX: begin
              if (slot_in_range) begin
                idx_nxt  = CW'(qc.slot) + CW'(1);
                pidx_nxt = CW'(qc.slot);
              end else begin
                res_nxt.status = kmt_pkg::ST_NONE;
              end
            end
            kmt_pkg::OP_READ: begin
              if (count_r == '0) begin
                res_nxt.status = kmt_pkg::ST_NONE;
              end else begin
                rem_nxt = XW'(qc.slot);
              end
            end
            default: ;
          endcase
        end
      end
      kmt_pkg::BS_SCAN: begin
        // one read issued per cycle, compared the cycle after
        if (issue_ok && !scan_hit) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r[AW-1:0];
          idx_nxt   = idx_r + CW'(1);
          pidx_nxt  = idx_r;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && cmd_r.op == kmt_pkg::OP_CLASSIFY && gh_eq && ram_rdata.name_blank) begin
          res_nxt.match_class = kmt_pkg::MC_GROUP;
        end
        if (scan_hit) begin
          case (cmd_r.op)
            kmt_pkg::OP_ADD:      res_nxt.status = kmt_pkg::ST_DUP;
            kmt_pkg::OP_RM_KEY: begin
              idx_nxt  = pidx_r + CW'(1);
              pidx_nxt = pidx_r;
              pend_nxt = 1'b0;
            end
            kmt_pkg::OP_CLASSIFY: res_nxt.match_class = kmt_pkg::MC_EXACT;
            kmt_pkg::OP_MEMBER:   res_nxt.is_member = 1'b1;
            default: ;
          endcase
        end else if (walk_end) begin
          case (cmd_r.op)
            kmt_pkg::OP_ADD: begin
              ram_we               = 1'b1;
              ram_waddr            = count_r[AW-1:0];
              ram_wdata.name_hash  = cmd_r.name_hash;
              ram_wdata.group_hash = cmd_r.group_hash;
              ram_wdata.name_blank = cmd_r.name_blank;
              count_nxt            = count_r + CW'(1);
            end
            kmt_pkg::OP_RM_KEY: res_nxt.status = kmt_pkg::ST_NONE;
            default: ;
          endcase
        end
      end
      kmt_pkg::BS_SHIFT: begin
        // entry read from slot j is written back to slot j-1
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = hole_addr[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (issue_ok) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r[AW-1:0];
          idx_nxt   = idx_r + CW'(1);
          pidx_nxt  = idx_r;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (walk_end) begin
          count_nxt = count_r - CW'(1);
        end
      end
      kmt_pkg::BS_MOD: begin
        // slot modulo count by repeated subtraction
        if (rem_ge) begin
          rem_nxt = rem_r - XW'(count_r);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = rem_r[AW-1:0];
        end
      end
      kmt_pkg::BS_RDDATA: begin
        res_nxt.read_name_hash  = ram_rdata.name_hash;
        res_nxt.read_group_hash = ram_rdata.group_hash;
        res_nxt.read_name_blank = ram_rdata.name_blank;
      end
      kmt_pkg::BS_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_load | (out_valid_r & !out_ready);
    out_nxt       = out_r;
    if (out_load) begin
      out_nxt             = res_r;
      out_nxt.entry_count = cnt_ext[kmt_pkg::COUNT_OUT_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kmt_pkg::BS_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    res_r  <= res_nxt;
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    rem_r  <= rem_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* tb/keyed_match_table_with_wildcards_checker.sv */
// Checker for the keyed match table: predicts each result item and compares it.
module keyed_match_table_with_wildcards_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  kmt_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  kmt_pkg::out_t out_data,
  output int            fail_count,
  output int            pending,
  output int            checked_count,
  output int            full_hits,
  output int            peak_held
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the table, packed in slots 0 .. held-1
  kmt_pkg::entry_t shadow_tbl [TABLE_DEPTH];
  int              held;

  // Results predicted for accepted items, oldest first
  kmt_pkg::out_t   awaited_results [$];

  // First slot holding exactly this key, or held when absent
  function automatic int key_slot(logic [kmt_pkg::HASH_W-1:0] nh,
                                  logic [kmt_pkg::HASH_W-1:0] gh);
    for (int i = 0; i < held; i++) begin
      if (shadow_tbl[i].name_hash == nh && shadow_tbl[i].group_hash == gh) return i;
    end
    return held;
  endfunction

  // Close the gap left by a removed entry
  function automatic void drop_slot(int idx);
    for (int i = idx; i + 1 < held; i++) shadow_tbl[i] = shadow_tbl[i + 1];
    held--;
  endfunction

  // Apply one action to the shadow table and build its result item
  function automatic kmt_pkg::out_t table_action_result(kmt_pkg::in_t item);
    kmt_pkg::out_t r;
    int            idx;
    r = '0;
    case (item.action)
      kmt_pkg::ACT_ADD: begin
        if (held >= TABLE_DEPTH) begin
          r.status = kmt_pkg::ST_FULL;
        end else if (item.name_blank && item.group_blank) begin
          r.status = kmt_pkg::ST_BLANK;
        end else if (key_slot(item.name_hash, item.group_hash) < held) begin
          r.status = kmt_pkg::ST_DUP;
        end else begin
          shadow_tbl[held] = '{item.name_hash, item.group_hash, item.name_blank};
          held++;
        end
      end
      kmt_pkg::ACT_RM_KEY: begin
        idx = key_slot(item.name_hash, item.group_hash);
        if (idx < held) drop_slot(idx);
        else r.status = kmt_pkg::ST_NONE;
      end
      kmt_pkg::ACT_RM_IDX: begin
        if (int'(item.slot) < held) drop_slot(int'(item.slot));
        else r.status = kmt_pkg::ST_NONE;
      end
      kmt_pkg::ACT_CLASSIFY: begin
        // wildcard gives group; a real name match gives exact and stops
        for (int i = 0; i < held; i++) begin
          if (shadow_tbl[i].group_hash == item.group_hash) begin
            if (shadow_tbl[i].name_blank) begin
              r.match_class = kmt_pkg::MC_GROUP;
            end else if (shadow_tbl[i].name_hash == item.name_hash) begin
              r.match_class = kmt_pkg::MC_EXACT;
              break;
            end
          end
        end
      end
      kmt_pkg::ACT_MEMBER: begin
        for (int i = 0; i < held; i++) begin
          if (shadow_tbl[i].group_hash == item.group_hash &&
              ((!item.players_only && shadow_tbl[i].name_blank) ||
               shadow_tbl[i].name_hash == item.name_hash)) begin
            r.is_member = 1'b1;
            break;
          end
        end
      end
      kmt_pkg::ACT_READ: begin
        if (held == 0) begin
          r.status = kmt_pkg::ST_NONE;
        end else begin
          idx = int'(item.slot) % held;
          r.read_name_hash  = shadow_tbl[idx].name_hash;
          r.read_group_hash = shadow_tbl[idx].group_hash;
          r.read_name_blank = shadow_tbl[idx].name_blank;
        end
      end
      default: ;
    endcase
    r.entry_count = held[kmt_pkg::COUNT_OUT_W-1:0];
    return r;
  endfunction

  // Watch both channels; a result is checked before the same edge's input is predicted
  always @(posedge clk) begin
    kmt_pkg::out_t want;
    logic          bad;
    if (!rst_n) begin
      held = 0;
      awaited_results.delete();
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < 10) $display("%0t unexpected result item: %p", $time, out_data);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          checked_count++;
          bad = (want.status          !== out_data.status)          ||
                (want.match_class     !== out_data.match_class)     ||
                (want.is_member       !== out_data.is_member)       ||
                (want.entry_count     !== out_data.entry_count)     ||
                (want.read_name_hash  !== out_data.read_name_hash)  ||
                (want.read_group_hash !== out_data.read_group_hash) ||
                (want.read_name_blank !== out_data.read_name_blank);
          if (bad) begin
            if (fail_count < 10) begin
              $display("%0t mismatch (expected/actual): status %0d/%0d class %0d/%0d",
                       $time, want.status, out_data.status,
                       want.match_class, out_data.match_class);
              $display("  member %0d/%0d count %0d/%0d name %h/%h group %h/%h blank %0d/%0d",
                       want.is_member, out_data.is_member,
                       want.entry_count, out_data.entry_count,
                       want.read_name_hash, out_data.read_name_hash,
                       want.read_group_hash, out_data.read_group_hash,
                       want.read_name_blank, out_data.read_name_blank);
            end
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = table_action_result(in_data);
        awaited_results.push_back(want);
        if (want.status == kmt_pkg::ST_FULL) full_hits++;
        if (held > peak_held) peak_held = held;
      end
      pending = awaited_results.size();
    end
  end

endmodule

/* tb/keyed_match_table_with_wildcards_test.sv */
// Testbench top for the keyed match table: clock, reset, stimulus and verdict.
module keyed_match_table_with_wildcards_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Action codes the block treats as no-ops
  localparam logic [kmt_pkg::ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [kmt_pkg::ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  // Keys used by the directed part
  localparam logic [kmt_pkg::HASH_W-1:0] GRP_A  = 32'h00C0_FFEE;
  localparam logic [kmt_pkg::HASH_W-1:0] GRP_D  = 32'hDEAD_0D0D;
  localparam logic [kmt_pkg::HASH_W-1:0] NM_B   = 32'h0000_B0B0;
  localparam logic [kmt_pkg::HASH_W-1:0] NM_C   = 32'h0000_0C0C;
  localparam logic [kmt_pkg::HASH_W-1:0] NM_WLD = 32'h1234_5678;

  typedef enum int {FILL_UP, DRAIN_DOWN, MIXED} traffic_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  kmt_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  kmt_pkg::out_t out_data;

  bit   in_accepted;
  bit   out_accepted;
  bit   no_idle;

  int   fail_count, pending, checked_count, full_hits, peak_held;
  int   sent_per_action [8];

  logic [kmt_pkg::HASH_W-1:0] group_pool [8];
  logic [kmt_pkg::HASH_W-1:0] name_pool [10];

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  keyed_match_table_with_wildcards #(.TABLE_DEPTH(64)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  keyed_match_table_with_wildcards_checker #(.TABLE_DEPTH(64)) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .full_hits     (full_hits),
    .peak_held     (peak_held)
  );

  // Handshakes seen at the rising edge, read back at the falling edge
  always @(posedge clk) begin
    in_accepted  <= in_valid && in_ready;
    out_accepted <= out_valid && out_ready;
  end

  function automatic kmt_pkg::in_t mk(logic [kmt_pkg::ACTION_W-1:0] act,
                                      logic [kmt_pkg::HASH_W-1:0] nh,
                                      logic [kmt_pkg::HASH_W-1:0] gh,
                                      logic nb, logic gb, logic po,
                                      logic [kmt_pkg::SLOT_W-1:0] sl);
    kmt_pkg::in_t it;
    it.action       = act;
    it.name_hash    = nh;
    it.group_hash   = gh;
    it.name_blank   = nb;
    it.group_blank  = gb;
    it.players_only = po;
    it.slot         = sl;
    return it;
  endfunction

  // Mostly pooled hashes so keys repeat; some fully random
  function automatic logic [kmt_pkg::HASH_W-1:0] draw_hash(bit is_group, int rand_pct);
    if ($urandom_range(0, 99) < rand_pct) return $urandom;
    if (is_group) return group_pool[$urandom_range(0, 7)];
    return name_pool[$urandom_range(0, 9)];
  endfunction

  function automatic kmt_pkg::in_t random_item(traffic_t mode);
    kmt_pkg::in_t                 it;
    int unsigned                  cut [7];
    int unsigned                  pick;
    int                           k;
    logic [kmt_pkg::ACTION_W-1:0] acts [6];
    acts = '{kmt_pkg::ACT_ADD, kmt_pkg::ACT_RM_KEY, kmt_pkg::ACT_RM_IDX,
             kmt_pkg::ACT_CLASSIFY, kmt_pkg::ACT_MEMBER, kmt_pkg::ACT_READ};
    case (mode)
      FILL_UP:    cut = '{55, 60, 65, 77, 89, 97, 100};
      DRAIN_DOWN: cut = '{12, 36, 60, 72, 84, 97, 100};
      default:    cut = '{28, 40, 52, 70, 85, 97, 100};
    endcase
    pick = $urandom_range(0, 99);
    k = 0;
    while (pick >= cut[k]) k++;
    if (k == 6) it.action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    else it.action = acts[k];
    it.name_hash    = draw_hash(1'b0, (mode == FILL_UP && k == 0) ? 30 : 15);
    it.group_hash   = draw_hash(1'b1, (mode == FILL_UP && k == 0) ? 30 : 15);
    it.name_blank   = ($urandom_range(0, 99) < 25);
    it.group_blank  = ($urandom_range(0, 99) < 20);
    it.players_only = 1'($urandom_range(0, 1));
    it.slot         = 6'($urandom_range(0, 63));
    return it;
  endfunction

  // Drive one item at the falling edge and hold it until accepted
  task automatic send(kmt_pkg::in_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    sent_per_action[item.action]++;
    do @(negedge clk); while (!in_accepted);
  endtask

  // Result side: stall a random number of cycles before taking each item
  initial begin
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_accepted);
    end
  end

  // Stimulus and verdict
  initial begin
    traffic_t plan [13];
    plan = '{FILL_UP, FILL_UP, MIXED, DRAIN_DOWN, DRAIN_DOWN, FILL_UP, FILL_UP,
             MIXED, DRAIN_DOWN, MIXED, FILL_UP, DRAIN_DOWN, MIXED};
    group_pool[0] = '0;
    group_pool[1] = '1;
    for (int i = 2; i < 8; i++) group_pool[i] = $urandom;
    name_pool[0] = '0;
    name_pool[1] = '1;
    for (int i = 2; i < 10; i++) name_pool[i] = $urandom;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table: read, both removes miss
    send(mk(kmt_pkg::ACT_READ, '0, '0, 1'b0, 1'b0, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_RM_IDX, '0, '0, 1'b0, 1'b0, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_RM_KEY, '0, '0, 1'b0, 1'b0, 1'b0, 6'd0));
    // Blank key refused, then extreme keys added
    send(mk(kmt_pkg::ACT_ADD, NM_B, GRP_A, 1'b1, 1'b1, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_ADD, '0, '0, 1'b0, 1'b0, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_ADD, '1, '1, 1'b0, 1'b0, 1'b1, 6'd63));
    // Group wildcard ahead of a real member of the same group
    send(mk(kmt_pkg::ACT_ADD, NM_WLD, GRP_A, 1'b1, 1'b0, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_ADD, NM_B, GRP_A, 1'b0, 1'b0, 1'b0, 6'd0));
    // Duplicates, including one that differs only in the blank flag
    send(mk(kmt_pkg::ACT_ADD, NM_B, GRP_A, 1'b0, 1'b0, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_ADD, NM_WLD, GRP_A, 1'b0, 1'b0, 1'b0, 6'd0));
    // Classify: exact after wildcard, group only, blank-flag name hit, no group
    send(mk(kmt_pkg::ACT_CLASSIFY, NM_B, GRP_A, 1'b0, 1'b0, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_CLASSIFY, NM_C, GRP_A, 1'b0, 1'b0, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_CLASSIFY, NM_WLD, GRP_A, 1'b0, 1'b0, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_CLASSIFY, NM_B, GRP_D, 1'b0, 1'b0, 1'b0, 6'd0));
    // Membership with and without the players-only option
    send(mk(kmt_pkg::ACT_MEMBER, NM_C, GRP_A, 1'b0, 1'b0, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_MEMBER, NM_C, GRP_A, 1'b0, 1'b0, 1'b1, 6'd0));
    send(mk(kmt_pkg::ACT_MEMBER, NM_B, GRP_A, 1'b0, 1'b0, 1'b1, 6'd0));
    // Reads, one wrapping past the count
    send(mk(kmt_pkg::ACT_READ, '0, '0, 1'b0, 1'b0, 1'b0, 6'd63));
    send(mk(kmt_pkg::ACT_READ, '0, '0, 1'b0, 1'b0, 1'b0, 6'd1));
    // Unused action codes
    send(mk(ACT_SPARE_LO, '1, '1, 1'b1, 1'b1, 1'b1, 6'd63));
    send(mk(ACT_SPARE_HI, '1, '1, 1'b1, 1'b1, 1'b1, 6'd63));
    // Removes: by slot, by key, key gone, slot out of range
    send(mk(kmt_pkg::ACT_RM_IDX, '0, '0, 1'b0, 1'b0, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_RM_KEY, NM_B, GRP_A, 1'b0, 1'b0, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_RM_KEY, NM_B, GRP_A, 1'b0, 1'b0, 1'b0, 6'd0));
    send(mk(kmt_pkg::ACT_RM_IDX, '0, '0, 1'b0, 1'b0, 1'b0, 6'd63));
    // Blank group alone is a valid key
    send(mk(kmt_pkg::ACT_ADD, NM_C, '0, 1'b0, 1'b1, 1'b0, 6'd0));

    // Random traffic in phases that fill, drain and mix the table
    for (int seg = 0; seg < 13; seg++) begin
      no_idle = (seg % 4 == 2);
      repeat (150) send(random_item(plan[seg]));
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("run covered %0d results: add %0d, remove %0d/%0d, classify %0d, member %0d,",
             checked_count, sent_per_action[kmt_pkg::ACT_ADD],
             sent_per_action[kmt_pkg::ACT_RM_KEY], sent_per_action[kmt_pkg::ACT_RM_IDX],
             sent_per_action[kmt_pkg::ACT_CLASSIFY], sent_per_action[kmt_pkg::ACT_MEMBER]);
    $display("  read %0d, no-op %0d; table full refused %0d times, peak occupancy %0d",
             sent_per_action[kmt_pkg::ACT_READ],
             sent_per_action[ACT_SPARE_LO] + sent_per_action[ACT_SPARE_HI],
             full_hits, peak_held);
    if (fail_count == 0 && pending == 0) begin
      $display("** keyed_match_table_with_wildcards: PASSED **");
    end else begin
      $display("** keyed_match_table_with_wildcards: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("timeout: %0d results still awaited", pending);
    $display("** keyed_match_table_with_wildcards: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/kmt_pkg.sv
hdl/kmt_ram.sv
hdl/kmt_front.sv
hdl/kmt_back.sv
hdl/keyed_match_table_with_wildcards.sv
tb/keyed_match_table_with_wildcards_checker.sv
tb/keyed_match_table_with_wildcards_test.sv
